FILE: rtl/varint_zigzag_decoder_top_macros.svh
// assertion macros for the varint decoder
`ifndef VARINT_ZIGZAG_DECODER_TOP_MACROS_SVH
`define VARINT_ZIGZAG_DECODER_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define VZD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("varint decoder check failed");

// next-cycle implication, off during reset
`define VZD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("varint decoder check failed");

`endif

FILE: rtl/vzd_pkg.sv
`default_nettype none
package vzd_pkg;

  localparam int GROUP_BITS  = 7;
  localparam int LIMIT_SHORT = 5;
  localparam int LIMIT_LONG  = 10;
  localparam int TQ_DEPTH    = 4;
  localparam int TQ_PTR_W    = $clog2(TQ_DEPTH);
  localparam int TQ_CNT_W    = $clog2(TQ_DEPTH + 1);

  typedef logic [3:0] idx_t;

  // one classified stream byte
  typedef struct packed {
    logic [6:0] payload;
    idx_t       idx;
    logic       long_mode;
    logic       zigzag_mode;
    logic       last;
    logic       overrun;
  } tok_t;

  typedef struct packed {
    logic [63:0] decoded_value;
    logic        overrun;
    logic [3:0]  byte_count;
  } result_t;

  function automatic logic [5:0] shift_amount(input idx_t idx);
    logic [6:0] p;
    p = {3'b000, idx} * 7'(GROUP_BITS);
    return p[5:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/vzd_front.sv
`default_nettype none
module vzd_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic [7:0]  data_byte,
  input  wire logic        long_mode,
  input  wire logic        zigzag_mode,
  input  wire logic        q_full,
  output logic             tok_push,
  output vzd_pkg::tok_t    tok
);

  vzd_pkg::idx_t idx;
  vzd_pkg::idx_t idx_next;
  logic          held_long;
  logic          held_zigzag;
  logic          cur_long;
  logic          cur_zigzag;
  vzd_pkg::idx_t limit;
  vzd_pkg::idx_t idx_inc;
  logic          fin;

  assign tok_push   = push && !q_full;
  // modes are taken only from the first byte of a value
  assign cur_long   = (idx == '0) ? long_mode   : held_long;
  assign cur_zigzag = (idx == '0) ? zigzag_mode : held_zigzag;
  assign limit      = cur_long ? 4'(vzd_pkg::LIMIT_LONG) : 4'(vzd_pkg::LIMIT_SHORT);
  assign idx_inc    = 4'(idx + 4'd1);

  always_comb begin
    tok.payload     = data_byte[6:0];
    tok.idx         = idx;
    tok.long_mode   = cur_long;
    tok.zigzag_mode = cur_zigzag;
    tok.last        = !data_byte[7];
    tok.overrun     = data_byte[7] && (idx_inc == limit);
    fin             = tok.last || tok.overrun;
    idx_next        = fin ? '0 : idx_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      held_long   <= 1'b0;
      held_zigzag <= 1'b0;
    end else if (tok_push) begin
      idx         <= idx_next;
      held_long   <= cur_long;
      held_zigzag <= cur_zigzag;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vzd_tok_queue.sv
`default_nettype none
module vzd_tok_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire vzd_pkg::tok_t wr_data,
  output logic               full,
  input  wire logic          rd_en,
  output vzd_pkg::tok_t      rd_data,
  output logic               empty
);

  vzd_pkg::tok_t                  mem [vzd_pkg::TQ_DEPTH];
  logic [vzd_pkg::TQ_PTR_W-1:0]   wr_ptr;
  logic [vzd_pkg::TQ_PTR_W-1:0]   rd_ptr;
  logic [vzd_pkg::TQ_CNT_W-1:0]   count;
  logic                           do_wr;
  logic                           do_rd;

  assign full    = (count == vzd_pkg::TQ_CNT_W'(vzd_pkg::TQ_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= vzd_pkg::TQ_PTR_W'(wr_ptr + 1'b1);
      end
      if (do_rd) begin
        rd_ptr <= vzd_pkg::TQ_PTR_W'(rd_ptr + 1'b1);
      end
      if (do_wr && !do_rd) begin
        count <= vzd_pkg::TQ_CNT_W'(count + 1'b1);
      end else if (do_rd && !do_wr) begin
        count <= vzd_pkg::TQ_CNT_W'(count - 1'b1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vzd_back.sv
`default_nettype none
module vzd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          tok_valid,
  input  wire vzd_pkg::tok_t tok,
  output logic               tok_pop,
  output logic               empty,
  input  wire logic          pop,
  output vzd_pkg::result_t   result
);

  logic [63:0]        acc;
  logic [63:0]        acc_next;
  logic [63:0]        base;
  logic [63:0]        raw;
  logic [63:0]        finished;
  logic               fin;
  vzd_pkg::result_t   res_new;

  // two-entry result queue
  vzd_pkg::result_t   oq [2];
  logic               oq_wr;
  logic               oq_rd;
  logic [1:0]         oq_cnt;
  logic               oq_full;
  logic               oq_push;
  logic               oq_pop;

  function automatic logic [63:0] zz_finish(input logic [63:0] r, input logic lm,
                                           input logic zz);
    logic [31:0] v32;
    logic [63:0] v64;
    v32 = (r[31:0] >> 1) ^ {32{r[0]}};
    v64 = (r >> 1) ^ {64{r[0]}};
    if (lm) begin
      return zz ? v64 : r;
    end
    return zz ? {{32{v32[31]}}, v32} : {32'h0, r[31:0]};
  endfunction

  assign fin     = tok.last || tok.overrun;
  assign oq_full = oq_cnt[1];
  assign tok_pop = tok_valid && (!fin || !oq_full);
  assign oq_push = tok_pop && fin;
  assign empty   = (oq_cnt == 2'd0);
  assign oq_pop  = pop && !empty;
  assign result  = oq[oq_rd];

  always_comb begin
    base = (tok.idx == '0) ? 64'h0 : acc;
    raw  = base | ({57'h0, tok.payload} << vzd_pkg::shift_amount(tok.idx));
    if (!tok.long_mode) begin
      raw[63:32] = 32'h0;
    end
    finished               = zz_finish(raw, tok.long_mode, tok.zigzag_mode);
    res_new.decoded_value  = tok.overrun ? 64'h0 : finished;
    res_new.overrun        = tok.overrun;
    res_new.byte_count     = 4'(tok.idx + 4'd1);
    acc_next               = fin ? 64'h0 : raw;
  end

  always_ff @(posedge clk) begin
    if (tok_pop) begin
      acc <= acc_next;
    end
    if (oq_push) begin
      oq[oq_wr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr  <= 1'b0;
      oq_rd  <= 1'b0;
      oq_cnt <= 2'd0;
    end else begin
      if (oq_push) begin
        oq_wr <= !oq_wr;
      end
      if (oq_pop) begin
        oq_rd <= !oq_rd;
      end
      if (oq_push && !oq_pop) begin
        oq_cnt <= 2'(oq_cnt + 2'd1);
      end else if (oq_pop && !oq_push) begin
        oq_cnt <= 2'(oq_cnt - 2'd1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/varint_zigzag_decoder_top.sv
// varint decoder: one stream byte accepted per cycle while full is low
// a value's last byte is registered in the token queue, then the accumulate/finish stage
// writes its result into the result queue that drives the result ports (held while that is full)
// full rises only when the four-entry token queue and two-entry result queue back up
// synchronous reset empties both queues and waits for the first byte of a new value
`default_nettype none
`include "varint_zigzag_decoder_top_macros.svh"
module varint_zigzag_decoder_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire logic [7:0]   data_byte,
  input  wire logic         long_mode,
  input  wire logic         zigzag_mode,
  output logic              empty,
  input  wire logic         pop,
  output logic [63:0]       decoded_value,
  output logic              overrun,
  output logic [3:0]        byte_count
);

  logic               tq_push;
  logic               tq_full;
  logic               tq_pop;
  logic               tq_empty;
  vzd_pkg::tok_t      tok_in;
  vzd_pkg::tok_t      tok_out;
  vzd_pkg::result_t   result;

  assign full = tq_full;

  vzd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .data_byte   (data_byte),
    .long_mode   (long_mode),
    .zigzag_mode (zigzag_mode),
    .q_full      (tq_full),
    .tok_push    (tq_push),
    .tok         (tok_in)
  );

  vzd_tok_queue u_tq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tq_push),
    .wr_data (tok_in),
    .full    (tq_full),
    .rd_en   (tq_pop),
    .rd_data (tok_out),
    .empty   (tq_empty)
  );

  vzd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (!tq_empty),
    .tok       (tok_out),
    .tok_pop   (tq_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  assign decoded_value = result.decoded_value;
  assign overrun       = result.overrun;
  assign byte_count    = result.byte_count;

  // overrun transactions carry a zero value
  `VZD_ASSERT_NOW(a_ovr_zero, !empty && overrun, decoded_value == 64'h0)
  // overrun happens only at the byte limit
  `VZD_ASSERT_NOW(a_ovr_count, !empty && overrun, byte_count == 4'd5 || byte_count == 4'd10)
  // every result consumed between one and ten bytes
  `VZD_ASSERT_NOW(a_count_range, !empty, byte_count >= 4'd1 && byte_count <= 4'd10)
  // a result not taken stays on the ports
  `VZD_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(decoded_value))

endmodule
`default_nettype wire
